// ----- sv/cfp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_pkg
// shared types and constants of the framed byte parser
// ----------------------------------------------------------------------------
package cfp_pkg;

    // sync pattern
    localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND = 8'h55;

    // crc-16-ccitt, msb first, no final xor
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_SEED    = 16'hFFFF;

    // event codes of a result word
    localparam logic [2:0]  EV_FRAMING  = 3'd0;
    localparam logic [2:0]  EV_PAYLOAD  = 3'd1;
    localparam logic [2:0]  EV_ACCEPT   = 3'd2;
    localparam logic [2:0]  EV_REJECT   = 3'd3;
    localparam logic [2:0]  EV_OVERSIZE = 3'd4;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W   = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_VERSION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD_LEN  = 2'd1;

    // configuration reset values
    localparam logic [7:0]  EXPECTED_VERSION_RST = 8'd1;
    localparam logic [15:0] MAX_PAYLOAD_LEN_RST  = 16'd512;

    typedef struct packed {
        logic [7:0]  expected_version;
        logic [15:0] max_payload_len;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  data_byte;
        logic [15:0] payload_index;
        logic [7:0]  frame_type;
        logic [7:0]  frame_seq;
        logic [15:0] frame_len;
        logic [15:0] received_crc_out;
        logic        crc_ok;
        logic        version_ok;
    } res_t;

endpackage

// ----- sv/cfp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_if
// valid/ready channels for received bytes and parser result words
// ----------------------------------------------------------------------------

// received byte channel
interface cfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// result word channel
interface cfp_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  data_byte;
    logic [15:0] payload_index;
    logic [7:0]  frame_type;
    logic [7:0]  frame_seq;
    logic [15:0] frame_len;
    logic [15:0] received_crc_out;
    logic        crc_ok;
    logic        version_ok;

    modport source (
        output valid, output event_res, output data_byte, output payload_index,
        output frame_type, output frame_seq, output frame_len,
        output received_crc_out, output crc_ok, output version_ok,
        input ready
    );
    modport sink (
        input valid, input event_res, input data_byte, input payload_index,
        input frame_type, input frame_seq, input frame_len,
        input received_crc_out, input crc_ok, input version_ok,
        output ready
    );
endinterface

// ----- sv/crc_checked_frame_parser_top.sv -----
// ----------------------------------------------------------------------------
// crc_checked_frame_parser_top: sync/length framed byte parser with crc-16 check
// path: input byte register, then result register; one word per byte
// throughput: one byte per cycle unless res_ch stalls; crc update combinational
// reset: asynchronous active low, parser hunts for sync, config back to defaults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module crc_checked_frame_parser_top
    import cfp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    cfp_byte_if.sink             rx_ch,
    cfp_res_if.source            res_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_wdata
);

    cfg_t       cfg_reg;
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       out_valid_reg;
    logic       out_load;
    logic       step_en;
    logic       rx_accept;
    res_t       res;

    // handshake control of the two register stages
    assign out_load    = !out_valid_reg || res_ch.ready;
    assign step_en     = s1_valid_reg && out_load;
    assign rx_ch.ready = !s1_valid_reg || out_load;
    assign rx_accept   = rx_ch.valid && rx_ch.ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_version <= EXPECTED_VERSION_RST;
            cfg_reg.max_payload_len  <= MAX_PAYLOAD_LEN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_EXPECTED_VERSION: cfg_reg.expected_version <= cfg_wdata[7:0];
                CFG_MAX_PAYLOAD_LEN:  cfg_reg.max_payload_len  <= cfg_wdata;
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input register valid and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rx_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (step_en)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (step_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // input byte register
    always_ff @(posedge clk)
    begin
        if (rx_accept)
        begin
            s1_byte_reg <= rx_ch.rx_byte;
        end
    end

    cfp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .data    (s1_byte_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // result word onto the output channel
    assign res_ch.valid            = out_valid_reg;
    assign res_ch.event_res        = res.event_res;
    assign res_ch.data_byte        = res.data_byte;
    assign res_ch.payload_index    = res.payload_index;
    assign res_ch.frame_type       = res.frame_type;
    assign res_ch.frame_seq        = res.frame_seq;
    assign res_ch.frame_len        = res.frame_len;
    assign res_ch.received_crc_out = res.received_crc_out;
    assign res_ch.crc_ok           = res.crc_ok;
    assign res_ch.version_ok       = res.version_ok;

endmodule

// ----- sv/cfp_crc16.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_crc16
// byte-wide crc-16-ccitt update, eight shift steps unrolled
// ----------------------------------------------------------------------------
module cfp_crc16
    import cfp_pkg::*;
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);

    // fold the byte into the top half, then shift out eight bits
    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

// ----- sv/cfp_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_parser
// frame state machine with running crc and registered result word
// ----------------------------------------------------------------------------
module cfp_parser
    import cfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  logic [7:0] data,
    input  cfg_t       cfg,
    output res_t       res
);

    typedef enum logic [3:0] {
        PH_SYNC1 = 4'd0,
        PH_SYNC2 = 4'd1,
        PH_VER   = 4'd2,
        PH_TYPE  = 4'd3,
        PH_SEQ   = 4'd4,
        PH_LENH  = 4'd5,
        PH_LENL  = 4'd6,
        PH_DATA  = 4'd7,
        PH_CRCH  = 4'd8,
        PH_CRCL  = 4'd9
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  version_reg, version_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  seq_reg, seq_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] trailer_reg, trailer_next;
    res_t        res_reg, res_next;

    logic [15:0] crc_fed;
    logic [15:0] len_full;
    logic [15:0] trailer_full;
    logic        close;
    logic        wipe;

    cfp_crc16 u_crc (
        .crc_in  (crc_reg),
        .data    (data),
        .crc_out (crc_fed)
    );

    assign len_full     = {length_reg[15:8], data};
    assign trailer_full = {trailer_reg[15:8], data};

    // next state and result for the byte in the input register
    always_comb
    begin
        phase_next   = phase_reg;
        version_next = version_reg;
        type_next    = type_reg;
        seq_next     = seq_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        trailer_next = trailer_reg;
        close        = 1'b0;
        wipe         = 1'b0;

        res_next                  = '0;
        res_next.event_res        = EV_FRAMING;
        res_next.data_byte        = data;

        case (phase_reg)
            PH_SYNC1:
            begin
                if (data == SYNC_FIRST)
                begin
                    phase_next = PH_SYNC2;
                end
            end
            PH_SYNC2:
            begin
                if (data == SYNC_SECOND)
                begin
                    phase_next = PH_VER;
                    crc_next   = CRC_SEED;
                end
                else if (data != SYNC_FIRST)
                begin
                    wipe = 1'b1;
                end
            end
            PH_VER:
            begin
                version_next = data;
                crc_next     = crc_fed;
                phase_next   = PH_TYPE;
            end
            PH_TYPE:
            begin
                type_next  = data;
                crc_next   = crc_fed;
                phase_next = PH_SEQ;
            end
            PH_SEQ:
            begin
                seq_next   = data;
                crc_next   = crc_fed;
                phase_next = PH_LENH;
            end
            PH_LENH:
            begin
                length_next = {data, 8'h00};
                crc_next    = crc_fed;
                phase_next  = PH_LENL;
            end
            PH_LENL:
            begin
                length_next = len_full;
                crc_next    = crc_fed;
                count_next  = '0;
                if (len_full > cfg.max_payload_len)
                begin
                    res_next.event_res = EV_OVERSIZE;
                    close              = 1'b1;
                end
                else if (len_full == 16'd0)
                begin
                    phase_next = PH_CRCH;
                end
                else
                begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                res_next.event_res     = EV_PAYLOAD;
                res_next.payload_index = count_reg;
                crc_next               = crc_fed;
                count_next             = count_reg + 16'd1;
                if (count_next >= length_reg)
                begin
                    phase_next = PH_CRCH;
                end
            end
            PH_CRCH:
            begin
                trailer_next = {data, 8'h00};
                phase_next   = PH_CRCL;
            end
            PH_CRCL:
            begin
                trailer_next              = trailer_full;
                res_next.received_crc_out = trailer_full;
                res_next.crc_ok           = (crc_reg == trailer_full);
                res_next.version_ok       = (version_reg == cfg.expected_version);
                res_next.event_res        = (res_next.crc_ok && res_next.version_ok)
                                            ? EV_ACCEPT : EV_REJECT;
                close                     = 1'b1;
            end
            default:
            begin
                wipe = 1'b1;
            end
        endcase

        // header fields as they stand after this byte, zero after an early resync
        if (wipe)
        begin
            res_next.frame_type = '0;
            res_next.frame_seq  = '0;
            res_next.frame_len  = '0;
        end
        else
        begin
            res_next.frame_type = type_next;
            res_next.frame_seq  = seq_next;
            res_next.frame_len  = length_next;
        end

        // resync clears the held frame
        if (close || wipe)
        begin
            phase_next   = PH_SYNC1;
            version_next = '0;
            type_next    = '0;
            seq_next     = '0;
            length_next  = '0;
            count_next   = '0;
            crc_next     = CRC_SEED;
            trailer_next = '0;
        end
    end

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SYNC1;
            version_reg <= '0;
            type_reg    <= '0;
            seq_reg     <= '0;
            length_reg  <= '0;
            count_reg   <= '0;
            crc_reg     <= CRC_SEED;
            trailer_reg <= '0;
            res_reg     <= '0;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            version_reg <= version_next;
            type_reg    <= type_next;
            seq_reg     <= seq_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            trailer_reg <= trailer_next;
            res_reg     <= res_next;
        end
    end

    assign res = res_reg;

`ifndef SYNTHESIS
    // payload index always lies inside the announced length
    a_index_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        res_reg.event_res == EV_PAYLOAD |-> res_reg.payload_index < res_reg.frame_len)
        else $error("payload index beyond frame length");

    // an accepted frame passed both checks
    a_accept_checks: assert property (@(posedge clk) disable iff (!rst_n)
        res_reg.event_res == EV_ACCEPT |-> res_reg.crc_ok && res_reg.version_ok)
        else $error("accept without passing checks");

    // check flags and trailer only on end words
    a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (res_reg.event_res != EV_ACCEPT && res_reg.event_res != EV_REJECT)
        |-> !res_reg.crc_ok && !res_reg.version_ok && res_reg.received_crc_out == 16'd0)
        else $error("end fields set on non-end word");

    // hunting phase always holds a clean frame context
    a_hunt_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SYNC1 || phase_reg == PH_SYNC2)
        |-> crc_reg == CRC_SEED && length_reg == 16'd0 && count_reg == 16'd0)
        else $error("stale frame state while hunting");
`endif

endmodule
